// File: hdl/rpq_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the RGB palette quantizer.
// Used by rpq_cfg, rpq_cell and rgb_palette_quantizer_unit. No dependencies.
package rpq_pkg;

    // APB address width: three 32-bit registers at byte offsets 0, 4, 8
    localparam int ADDR_W = 4;

    // Probe ring geometry: slot s lives in cell s mod NUM_CELLS
    localparam int NUM_CELLS = 4;
    localparam int CELL_W    = 2;

    // Image generation tag kept with every table entry; tag 0 marks a wiped entry
    localparam int EPOCH_W = 4;

    localparam int COLOUR_W = 24;

    localparam logic [31:0] HASH_MULT = 32'd2654435761;
    localparam logic [7:0]  ALPHA_CUT = 8'd128;
    localparam logic [7:0]  CUBE_STEP = 8'd43;

    // Register map
    typedef enum logic [1:0] {
        REG_ALPHA_ENABLE  = 2'd0,
        REG_FIXED_MODE    = 2'd1,
        REG_PALETTE_LIMIT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic       alpha_enable;
        logic       fixed_mode;
        logic [7:0] palette_limit;
    } cfg_t;

    // One table entry in a cell bank
    typedef struct packed {
        logic [EPOCH_W-1:0]  tag;
        logic [COLOUR_W-1:0] colour;
        logic [7:0]          index;
    } entry_t;

    // Shared context driven by the controller into every cell
    typedef struct packed {
        logic               clr_en;
        logic [EPOCH_W-1:0] epoch;
        logic               new_ok;
        logic [7:0]         new_index;
    } ctx_t;

    // Probe outcome reported by a cell
    typedef struct packed {
        logic       valid;
        logic       fail;
        logic       added;
        logic [7:0] index;
    } done_t;

    // Cube level: min(v / 43, 5) by threshold compare
    function automatic logic [2:0] cube_level(input logic [7:0] v);
        logic [2:0] lvl;
        if (v >= 8'(5 * CUBE_STEP))
            lvl = 3'd5;
        else if (v >= 8'(4 * CUBE_STEP))
            lvl = 3'd4;
        else if (v >= 8'(3 * CUBE_STEP))
            lvl = 3'd3;
        else if (v >= 8'(2 * CUBE_STEP))
            lvl = 3'd2;
        else if (v >= CUBE_STEP)
            lvl = 3'd1;
        else
            lvl = 3'd0;
        return lvl;
    endfunction

    // Fixed 6x6x6 cube index, 1-based
    function automatic logic [7:0] cube_index(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
        logic [7:0] lr;
        logic [7:0] lg;
        logic [7:0] lb;
        lr = {5'd0, cube_level(r)};
        lg = {5'd0, cube_level(g)};
        lb = {5'd0, cube_level(b)};
        return 8'(lr * 8'd36 + lg * 8'd6 + lb + 8'd1);
    endfunction

endpackage

// File: hdl/rgb_palette_quantizer_unit.sv
`timescale 1ns / 1ps
// Top level of the RGB palette quantizer: controller, hash and the probe ring.
// Depends on rpq_pkg, rpq_cfg and rpq_cell.
//
// Usage:
//   Pixels enter on the in_valid/in_ready channel, one beat per pixel, and one
//   result beat per pixel leaves on out_valid/out_ready in the same order.
//   The user must write registers over the APB port only while no pixel is in
//   flight; the block does not enforce this. One pixel is worked on at a time.
//   A transparent, fixed-mode or overflowed pixel is accepted and then handed
//   to the output register. A dynamic pixel is accepted, starts the first bank
//   read, then is read and compared in a ring cell at each slot its linear probe
//   visits, and is handed to the output register. The table is split over a
//   ring of 4 cells, slot s in cell s mod 4. Entries carry an image tag;
//   ending an image bumps the tag, which empties the table at once. After
//   reset, and after every 15th image, a clearing sweep over all TABLE_SLOTS/4
//   bank addresses (256 by default) wipes all banks while in_ready stays low;
//   APB writes are taken during the sweep.
//   The result sits in an output register, so a finished pixel can wait on a
//   stalled receiver while the next pixel is accepted; the second pixel then
//   holds in its final cycle until the output register frees up.
module rgb_palette_quantizer_unit #(
    parameter int TABLE_SLOTS     = 1024,
    parameter int PALETTE_ENTRIES = 255
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rpq_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 red,
    input  logic [7:0]                 green,
    input  logic [7:0]                 blue,
    input  logic [7:0]                 alpha,
    input  logic                       last_pixel,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 palette_index,
    output logic                       new_color,
    output logic                       overflow,
    output logic [7:0]                 colors_used
);

    localparam int SLOT_W     = $clog2(TABLE_SLOTS);
    localparam int BANK_W     = $clog2(TABLE_SLOTS / rpq_pkg::NUM_CELLS);
    localparam int NC         = rpq_pkg::NUM_CELLS;
    localparam int CW         = rpq_pkg::COLOUR_W;
    localparam int EW         = rpq_pkg::EPOCH_W;

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_LAUNCH = 5'b00100,
        ST_PROBE  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    rpq_pkg::cfg_t cfg;

    // Control state
    state_t            state_reg, state_next;
    logic [BANK_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [EW-1:0]     epoch_reg, epoch_next;
    logic [7:0]        count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic              out_valid_reg, out_valid_next;

    // Pixel in flight
    logic [CW-1:0]     colour_reg, colour_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              last_reg, last_next;
    logic [7:0]        res_index_reg, res_index_next;
    logic              res_added_reg, res_added_next;

    // Output beat
    logic [7:0] pidx_reg;
    logic       newc_reg;
    logic       ovf_out_reg;
    logic [7:0] used_reg;

    logic          launch;
    logic          out_load;
    logic [CW-1:0] colour_in;
    logic [7:0]    eff_limit;
    rpq_pkg::ctx_t  ctx;
    rpq_pkg::done_t done_any;

    // Ring wiring
    logic              c_valid [NC];
    logic [CW-1:0]     c_colour [NC];
    logic [SLOT_W-1:0] c_slot [NC];
    logic [SLOT_W-1:0] c_tries [NC];
    logic              t_valid [NC];
    logic [CW-1:0]     t_colour [NC];
    logic [SLOT_W-1:0] t_slot [NC];
    logic [SLOT_W-1:0] t_tries [NC];
    rpq_pkg::done_t    done_arr [NC];

    rpq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign colour_in = {red, green, blue};
    assign eff_limit = (cfg.palette_limit > 8'(PALETTE_ENTRIES)) ?
                       8'(PALETTE_ENTRIES) : cfg.palette_limit;

    // Context shared by all cells
    assign ctx.clr_en    = (state_reg == ST_CLEAR);
    assign ctx.epoch     = epoch_reg;
    assign ctx.new_ok    = (count_reg < eff_limit);
    assign ctx.new_index = count_reg + 8'd1;

    // Build the ring; the launch enters at the cell that owns the home slot
    genvar gi;
    generate
        for (gi = 0; gi < NC; gi++)
        begin : g_cell
            localparam int PREV = (gi + NC - 1) % NC;

            assign c_valid[gi]  = t_valid[PREV] |
                                  (launch && (slot_reg[rpq_pkg::CELL_W-1:0] ==
                                              rpq_pkg::CELL_W'(gi)));
            assign c_colour[gi] = launch ? colour_reg : t_colour[PREV];
            assign c_slot[gi]   = launch ? slot_reg : t_slot[PREV];
            assign c_tries[gi]  = launch ? '0 : t_tries[PREV];

            rpq_cell #(
                .TABLE_SLOTS (TABLE_SLOTS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctx         (ctx),
                .clr_addr    (clr_cnt_reg),
                .tin_valid   (c_valid[gi]),
                .tin_colour  (c_colour[gi]),
                .tin_slot    (c_slot[gi]),
                .tin_tries   (c_tries[gi]),
                .tout_valid  (t_valid[gi]),
                .tout_colour (t_colour[gi]),
                .tout_slot   (t_slot[gi]),
                .tout_tries  (t_tries[gi]),
                .done        (done_arr[gi])
            );
        end
    endgenerate

    // Merge cell reports; at most one cell holds the probe
    always_comb
    begin
        done_any = '0;
        for (int i = 0; i < NC; i++)
            done_any = rpq_pkg::done_t'(done_any | done_arr[i]);
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        epoch_next     = epoch_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg & !out_ready;
        colour_next    = colour_reg;
        slot_next      = slot_reg;
        last_next      = last_reg;
        res_index_next = res_index_reg;
        res_added_next = res_added_reg;
        launch         = 1'b0;
        out_load       = 1'b0;
        in_ready       = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    epoch_next = EW'(1);
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    colour_next    = colour_in;
                    slot_next      = SLOT_W'(colour_in[SLOT_W-1:0] *
                                             rpq_pkg::HASH_MULT[SLOT_W-1:0]);
                    last_next      = last_pixel;
                    res_added_next = 1'b0;
                    res_index_next = 8'd0;
                    if (cfg.alpha_enable && (alpha < rpq_pkg::ALPHA_CUT))
                        state_next = ST_FINISH;
                    else if (cfg.fixed_mode)
                    begin
                        res_index_next = rpq_pkg::cube_index(red, green, blue);
                        state_next     = ST_FINISH;
                    end
                    else if (ovf_reg)
                        state_next = ST_FINISH;
                    else
                        state_next = ST_LAUNCH;
                end
            end

            ST_LAUNCH:
            begin
                launch     = 1'b1;
                state_next = ST_PROBE;
            end

            ST_PROBE:
            begin
                if (done_any.valid)
                begin
                    if (done_any.fail)
                    begin
                        ovf_next       = 1'b1;
                        res_index_next = 8'd0;
                    end
                    else
                        res_index_next = done_any.index;
                    if (done_any.added)
                    begin
                        count_next     = count_reg + 8'd1;
                        res_added_next = 1'b1;
                    end
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (last_reg)
                    begin
                        count_next = 8'd0;
                        ovf_next   = 1'b0;
                        if (&epoch_reg)
                        begin
                            clr_cnt_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        else
                            epoch_next = epoch_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                clr_cnt_next = '0;
                state_next   = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            epoch_reg     <= EW'(1);
            count_reg     <= 8'd0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            epoch_reg     <= epoch_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Pixel payload
    always_ff @(posedge clk)
    begin
        colour_reg    <= colour_next;
        slot_reg      <= slot_next;
        last_reg      <= last_next;
        res_index_reg <= res_index_next;
        res_added_reg <= res_added_next;
    end

    // Capture the result beat; overflow and count are sampled before any clear
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pidx_reg    <= res_index_reg;
            newc_reg    <= res_added_reg;
            ovf_out_reg <= ovf_reg;
            used_reg    <= count_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign palette_index = pidx_reg;
    assign new_color     = newc_reg;
    assign overflow      = ovf_out_reg;
    assign colors_used   = used_reg;

endmodule

// File: hdl/rpq_cfg.sv
`timescale 1ns / 1ps
// APB register file of the RGB palette quantizer.
// Depends on rpq_pkg for the register map and the cfg_t bundle.
module rpq_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rpq_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output rpq_pkg::cfg_t              cfg
);

    rpq_pkg::cfg_t     cfg_reg;
    rpq_pkg::cfg_t     cfg_next;
    rpq_pkg::reg_idx_t reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = rpq_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    // Decode writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                rpq_pkg::REG_ALPHA_ENABLE:  cfg_next.alpha_enable  = pwdata[0];
                rpq_pkg::REG_FIXED_MODE:    cfg_next.fixed_mode    = pwdata[0];
                rpq_pkg::REG_PALETTE_LIMIT: cfg_next.palette_limit = pwdata[7:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Decode reads
    always_comb
    begin
        unique case (reg_idx)
            rpq_pkg::REG_ALPHA_ENABLE:  prdata = {31'd0, cfg_reg.alpha_enable};
            rpq_pkg::REG_FIXED_MODE:    prdata = {31'd0, cfg_reg.fixed_mode};
            rpq_pkg::REG_PALETTE_LIMIT: prdata = {24'd0, cfg_reg.palette_limit};
            default:                    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha_enable  <= 1'b0;
            cfg_reg.fixed_mode    <= 1'b0;
            cfg_reg.palette_limit <= 8'd255;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hdl/rpq_cell.sv
`timescale 1ns / 1ps
// One probe cell of the hash ring: a bank of table slots plus the probe stage.
// Depends on rpq_pkg for entry_t, ctx_t and done_t.
module rpq_cell #(
    parameter int TABLE_SLOTS = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rpq_pkg::ctx_t                ctx,
    input  logic [$clog2(TABLE_SLOTS/rpq_pkg::NUM_CELLS)-1:0] clr_addr,
    input  logic                         tin_valid,
    input  logic [rpq_pkg::COLOUR_W-1:0] tin_colour,
    input  logic [$clog2(TABLE_SLOTS)-1:0] tin_slot,
    input  logic [$clog2(TABLE_SLOTS)-1:0] tin_tries,
    output logic                         tout_valid,
    output logic [rpq_pkg::COLOUR_W-1:0] tout_colour,
    output logic [$clog2(TABLE_SLOTS)-1:0] tout_slot,
    output logic [$clog2(TABLE_SLOTS)-1:0] tout_tries,
    output rpq_pkg::done_t               done
);

    localparam int SLOT_W     = $clog2(TABLE_SLOTS);
    localparam int BANK_DEPTH = TABLE_SLOTS / rpq_pkg::NUM_CELLS;
    localparam int BANK_W     = $clog2(BANK_DEPTH);

    rpq_pkg::entry_t bank_mem [BANK_DEPTH];
    rpq_pkg::entry_t rd_reg;
    rpq_pkg::entry_t wr_data;
    logic [BANK_W-1:0] wr_addr;
    logic              wr_en;

    logic                         pend_reg;
    logic [rpq_pkg::COLOUR_W-1:0] colour_reg;
    logic [SLOT_W-1:0]            slot_reg;
    logic [SLOT_W-1:0]            tries_reg;

    logic live;
    logic empty;
    logic match;
    logic last_try;

    // Classify the slot just read
    assign live     = (rd_reg.tag == ctx.epoch);
    assign empty    = !live;
    assign match    = live && (rd_reg.colour == colour_reg);
    assign last_try = &tries_reg;

    // Report a finished probe; an idle cell reports all zero so reports can be merged
    assign done.valid = pend_reg & (empty | match | last_try);
    assign done.fail  = pend_reg & ((empty & !ctx.new_ok) | (!empty & !match & last_try));
    assign done.added = pend_reg & empty & ctx.new_ok;
    assign done.index = !pend_reg ? 8'd0 : (match ? rd_reg.index : ctx.new_index);

    // Hand the probe to the next slot on a collision
    assign tout_valid  = pend_reg & !empty & !match & !last_try;
    assign tout_colour = colour_reg;
    assign tout_slot   = slot_reg + 1'b1;
    assign tout_tries  = tries_reg + 1'b1;

    // Bank write: clearing sweep or new entry
    always_comb
    begin
        wr_en = ctx.clr_en | done.added;
        if (ctx.clr_en)
        begin
            wr_addr = clr_addr;
            wr_data = '0;
        end
        else
        begin
            wr_addr        = slot_reg[SLOT_W-1:rpq_pkg::CELL_W];
            wr_data.tag    = ctx.epoch;
            wr_data.colour = colour_reg;
            wr_data.index  = ctx.new_index;
        end
    end

    // Bank storage with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            bank_mem[wr_addr] <= wr_data;
        if (tin_valid)
            rd_reg <= bank_mem[tin_slot[SLOT_W-1:rpq_pkg::CELL_W]];
    end

    // Hold the probe while its slot is read
    always_ff @(posedge clk)
    begin
        if (tin_valid)
        begin
            colour_reg <= tin_colour;
            slot_reg   <= tin_slot;
            tries_reg  <= tin_tries;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else
            pend_reg <= tin_valid;
    end

endmodule

// File: hdl/rpq_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the RGB palette quantizer, bound to the top level.
// Depends only on the ports of rgb_palette_quantizer_unit.
module rpq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] palette_index,
    input logic       new_color,
    input logic       overflow,
    input logic [7:0] colors_used
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(palette_index) &&
        $stable(new_color) && $stable(overflow) && $stable(colors_used))
        else $error("stalled result beat changed");

    // A new entry never comes with overflow
    a_new_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && new_color |-> !overflow)
        else $error("new color flagged together with overflow");

    // A new entry takes the next index, so it equals the count after it
    a_new_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && new_color |-> (palette_index == colors_used) &&
        (palette_index != 8'd0))
        else $error("new color index does not match count");

    // One pixel at a time: input closes right after a beat is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on consecutive cycles");

endmodule

bind rgb_palette_quantizer_unit rpq_checker u_rpq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .palette_index (palette_index),
    .new_color     (new_color),
    .overflow      (overflow),
    .colors_used   (colors_used)
);
